// ===== rtl/lch_pkg.sv =====
// Package with the constants, opcodes, status codes and state encoding of the letter context histogram.
package lch_pkg;
   localparam int MaxLettersDefault = 64;
   localparam int CountBitsDefault  = 32;
   localparam int FracBitsDefault   = 16;
   localparam int CodeBits          = 21;
   localparam int IndexBits         = 6;

   typedef enum logic [1:0] {
      OP_DEFINE = 2'd0,
      OP_CHAR   = 2'd1,
      OP_EOL    = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_IDX = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_ACT,
      S_RMW_RD,
      S_RMW_WR,
      S_DIVIDE,
      S_RESPOND
   } state_type;

   localparam logic [1:0] ClsVow = 2'b01;
   localparam logic [1:0] ClsCon = 2'b10;
endpackage

// ===== rtl/lch_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface lch_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/letter_context_histogram_unit.sv =====
// Top level of the letter context histogram: one request in, one response out.
//
// Each transfer on the request channel produces exactly one response transfer. Requests are
// handled one at a time. A define or a text character searches the letter table one entry per
// cycle through the single memory port; a text character then adds two read-modify-write passes
// over the counter memory. A read uses the shared restoring divider for each of the two share
// pairs. End of line goes straight to the response. The counter memory holds the four counters
// of each entry side by side; after reset the memory is swept to zero, one entry per cycle,
// before the first request is taken.
module letter_context_histogram_unit #(
   parameter int MaxLetters = lch_pkg::MaxLettersDefault,
   parameter int CountBits  = lch_pkg::CountBitsDefault,
   parameter int FracBits   = lch_pkg::FracBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [lch_pkg::CodeBits-1:0]  req_code_point,
   input  logic                          req_is_vowel,
   input  logic                          req_is_consonant,
   input  logic [lch_pkg::IndexBits-1:0] req_entry_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [lch_pkg::CodeBits-1:0]  rsp_letter_code,
   output logic [FracBits:0]             rsp_con_before_share,
   output logic [FracBits:0]             rsp_vow_before_share,
   output logic [FracBits:0]             rsp_con_after_share,
   output logic [FracBits:0]             rsp_vow_after_share,
   output logic [CountBits-1:0]          rsp_con_before_count,
   output logic [CountBits-1:0]          rsp_vow_before_count,
   output logic [CountBits-1:0]          rsp_con_after_count,
   output logic [CountBits-1:0]          rsp_vow_after_count
);
   import lch_pkg::*;

   localparam int AW = $clog2(MaxLetters);
   localparam int NW = $clog2(MaxLetters + 1);
   localparam int LW = CodeBits + 2;
   localparam int CW = 4 * CountBits;
   localparam int SW = $clog2(FracBits + 2);
   localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};
   // Counter word layout: con_before, vow_before, con_after, vow_after from the top.

   state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;       // letters defined
   logic [NW-1:0] scan_ff, scan_in;         // search position
   logic          found_ff, found_in;
   logic [AW-1:0] hit_ff, hit_in;
   logic [1:0]    hcls_ff, hcls_in;
   logic [NW-1:0] clr_ff, clr_in;           // clearing pass position
   logic          clr_done_ff, clr_done_in;
   logic [1:0]    op_ff, op_in;
   logic [CodeBits-1:0] cp_ff, cp_in;
   logic [1:0]    cls_ff, cls_in;
   logic [IndexBits-1:0] idx_ff, idx_in;
   logic          pp_ff, pp_in, pt_ff, pt_in;
   logic [AW-1:0] pe_ff, pe_in;
   logic [1:0]    pc_ff, pc_in;
   logic          pass_ff, pass_in;         // 0 previous entry after-counts, 1 current before
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    st_ff, st_in;
   logic [CodeBits-1:0] lc_ff, lc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [4*(FracBits+1)-1:0] sh_ff, sh_in;
   // Divider.
   logic          dpair_ff, dpair_in;
   logic [SW-1:0] dstep_ff, dstep_in;
   logic [CountBits:0] rem_ff, rem_in, tot_ff, tot_in;
   logic [FracBits-1:0] q_ff, q_in;

   logic          lt_we, ct_we;
   logic [AW-1:0] lt_addr, ct_addr;
   logic [LW-1:0] lt_wd, lt_rd;
   logic [CW-1:0] ct_wd, ct_rd;

   lch_ram #(.Width(LW), .Depth(MaxLetters)) u_letters (
      .clock(clock), .wr_en(lt_we), .addr(lt_addr), .wr_data(lt_wd), .rd_data(lt_rd));
   lch_ram #(.Width(CW), .Depth(MaxLetters)) u_counts (
      .clock(clock), .wr_en(ct_we), .addr(ct_addr), .wr_data(ct_wd), .rd_data(ct_rd));

   function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] c, input logic en);
      bump = (en && c != CntMax) ? c + 1'b1 : c;
   endfunction

   logic accept, scan_end, lt_match;
   logic [CountBits-1:0] sel_con, sel_vow;
   logic [CountBits:0]   rem2;
   logic [CountBits+1:0] rem_sh;
   logic [CountBits+1:0] rem_sub;
   logic [1:0]           ncls;

   assign accept   = req_valid && req_ready;
   assign scan_end = (scan_ff == count_ff);
   assign lt_match = (lt_rd[LW-1:2] == cp_ff);
   assign sel_con  = dpair_ff ? cnt_ff[2*CountBits-1 -: CountBits] : cnt_ff[CW-1 -: CountBits];
   assign sel_vow  = dpair_ff ? cnt_ff[CountBits-1:0] : cnt_ff[3*CountBits-1 -: CountBits];
   assign rem_sh   = {rem_ff, 1'b0};
   assign rem_sub  = rem_sh - {1'b0, tot_ff};
   assign rem2     = (rem_sh >= {1'b0, tot_ff}) ? rem_sub[CountBits:0] : rem_sh[CountBits:0];
   assign ncls     = found_ff ? hcls_ff : 2'b00;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_op))
                  OP_DEFINE, OP_CHAR: state_in = S_SEARCH;
                  OP_EOL:             state_in = S_RESPOND;
                  OP_READ:            state_in = S_SEARCH;
                  default:            state_in = S_RESPOND;
               endcase
            end
         end
         S_SEARCH: begin
            if (op_ff == OP_READ) state_in = S_ACT;
            else if (scan_end || (scan_ff != '0 && lt_match)) state_in = S_ACT;
         end
         S_ACT: begin
            if (op_ff == OP_CHAR) state_in = S_RMW_RD;
            else if (op_ff == OP_READ && found_ff) state_in = S_DIVIDE;
            else state_in = S_RESPOND;
         end
         S_RMW_RD: state_in = S_RMW_WR;
         S_RMW_WR: state_in = pass_ff ? S_RESPOND : S_RMW_RD;
         S_DIVIDE: begin
            if (dpair_ff && dstep_ff == SW'(FracBits + 1)) state_in = S_RESPOND;
         end
         S_RESPOND: if (rsp_valid_ff && rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      count_in = count_ff; scan_in = scan_ff; found_in = found_ff; hit_in = hit_ff;
      hcls_in = hcls_ff; clr_in = clr_ff; clr_done_in = clr_done_ff;
      op_in = op_ff; cp_in = cp_ff; cls_in = cls_ff; idx_in = idx_ff;
      pp_in = pp_ff; pt_in = pt_ff; pe_in = pe_ff; pc_in = pc_ff; pass_in = pass_ff;
      rsp_valid_in = rsp_valid_ff; st_in = st_ff; lc_in = lc_ff; cnt_in = cnt_ff; sh_in = sh_ff;
      dpair_in = dpair_ff; dstep_in = dstep_ff; rem_in = rem_ff; tot_in = tot_ff; q_in = q_ff;
      lt_we = 1'b0; lt_addr = scan_ff[AW-1:0]; lt_wd = {cp_ff, cls_ff};
      ct_we = 1'b0; ct_addr = clr_ff[AW-1:0]; ct_wd = '0;
      req_ready = (state_ff == S_IDLE) && clr_done_ff;

      if (!clr_done_ff) begin
         ct_we = 1'b1;
         clr_in = clr_ff + 1'b1;
         if (clr_ff == NW'(MaxLetters - 1)) clr_done_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_op; cp_in = req_code_point;
               cls_in = {req_is_consonant, req_is_vowel};
               idx_in = req_entry_index;
               scan_in = '0; found_in = 1'b0; pass_in = 1'b0;
               st_in = ST_OK; lc_in = '0; cnt_in = '0; sh_in = '0;
               if (req_op == OP_EOL) begin
                  pp_in = 1'b0; pt_in = 1'b0; pe_in = '0; pc_in = 2'b00;
               end
            end
         end
         S_SEARCH: begin
            if (op_ff == OP_READ) begin
               // Read both memories at the requested entry.
               if ({{(NW > IndexBits ? NW - IndexBits : 0){1'b0}}, idx_ff} < NW'(count_ff)
                   && NW'(idx_ff) < NW'(MaxLetters)) begin
                  found_in = 1'b1;
               end
               lt_addr = AW'(idx_ff);
               ct_addr = AW'(idx_ff);
               hit_in = AW'(idx_ff);
            end else if (scan_ff != '0 && lt_match) begin
               found_in = 1'b1;
               hit_in = AW'(scan_ff - 1'b1);
               hcls_in = lt_rd[1:0];
            end else begin
               lt_addr = scan_ff[AW-1:0];
               if (!scan_end) scan_in = scan_ff + 1'b1;
            end
         end
         S_ACT: begin
            unique case (op_type'(op_ff))
               OP_DEFINE: begin
                  if (found_ff) begin
                     lt_we = 1'b1; lt_addr = hit_ff; lt_wd = {cp_ff, hcls_ff | cls_ff};
                  end else if (count_ff < NW'(MaxLetters)) begin
                     lt_we = 1'b1; lt_addr = count_ff[AW-1:0]; lt_wd = {cp_ff, cls_ff};
                     count_in = count_ff + 1'b1;
                  end else begin
                     st_in = ST_FULL;
                  end
               end
               OP_READ: begin
                  if (found_ff) begin
                     lc_in = lt_rd[LW-1:2];
                     cnt_in = ct_rd;
                     dpair_in = 1'b0; dstep_in = '0;
                  end else begin
                     st_in = ST_BAD_IDX;
                  end
               end
               default: ;
            endcase
         end
         S_RMW_RD: begin
            ct_addr = pass_ff ? hit_ff : pe_ff;
         end
         S_RMW_WR: begin
            ct_addr = pass_ff ? hit_ff : pe_ff;
            ct_wd = ct_rd;
            if (!pass_ff) begin
               if (pp_ff && pt_ff) begin
                  ct_we = 1'b1;
                  ct_wd[2*CountBits-1 -: CountBits] =
                     bump(ct_rd[2*CountBits-1 -: CountBits], ncls[1]);
                  ct_wd[CountBits-1:0] = bump(ct_rd[CountBits-1:0], ncls[0]);
               end
               pass_in = 1'b1;
            end else begin
               if (pp_ff && found_ff) begin
                  ct_we = 1'b1;
                  ct_wd[CW-1 -: CountBits] = bump(ct_rd[CW-1 -: CountBits], pc_ff[1]);
                  ct_wd[3*CountBits-1 -: CountBits] =
                     bump(ct_rd[3*CountBits-1 -: CountBits], pc_ff[0]);
               end
               pp_in = 1'b1; pt_in = found_ff;
               pe_in = found_ff ? hit_ff : '0;
               pc_in = ncls;
            end
         end
         S_DIVIDE: begin
            if (dstep_ff == '0) begin
               tot_in = {1'b0, sel_con} + {1'b0, sel_vow};
               rem_in = {1'b0, sel_con};
               q_in = '0;
               dstep_in = dstep_ff + 1'b1;
            end else if (dstep_ff <= SW'(FracBits)) begin
               rem_in = rem2;
               q_in = {q_ff[FracBits-2:0], (rem_sh >= {1'b0, tot_ff})};
               dstep_in = dstep_ff + 1'b1;
            end else begin
               // Store the pair and move on.
               if (tot_ff == '0) begin
                  sh_in[(dpair_ff ? 2 : 4)*(FracBits+1)-1 -: 2*(FracBits+1)] = '0;
               end else if (rem_ff[CountBits-1:0] == sel_con && {1'b0, sel_con} == tot_ff
                            && sel_vow == '0) begin
                  sh_in[(dpair_ff ? 2 : 4)*(FracBits+1)-1 -: 2*(FracBits+1)] =
                     {1'b1, {FracBits{1'b0}}, {(FracBits+1){1'b0}}};
               end else begin
                  sh_in[(dpair_ff ? 2 : 4)*(FracBits+1)-1 -: 2*(FracBits+1)] =
                     {1'b0, q_ff, (FracBits+1)'(1 << FracBits) - {1'b0, q_ff}};
               end
               dpair_in = 1'b1; dstep_in = '0;
            end
         end
         S_RESPOND: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
         end
         default: ;
      endcase
      if (state_ff == S_RESPOND && rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; clr_ff <= '0; clr_done_ff <= 1'b0;
         pp_ff <= 1'b0; pt_ff <= 1'b0; pe_ff <= '0; pc_ff <= '0;
         rsp_valid_ff <= 1'b0; dpair_ff <= 1'b0; dstep_ff <= '0; pass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; clr_ff <= clr_in; clr_done_ff <= clr_done_in;
         pp_ff <= pp_in; pt_ff <= pt_in; pe_ff <= pe_in; pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in; dpair_ff <= dpair_in; dstep_ff <= dstep_in;
         pass_ff <= pass_in;
      end
      scan_ff <= scan_in; found_ff <= found_in; hit_ff <= hit_in; hcls_ff <= hcls_in;
      op_ff <= op_in; cp_ff <= cp_in; cls_ff <= cls_in; idx_ff <= idx_in;
      st_ff <= st_in; lc_ff <= lc_in; cnt_ff <= cnt_in; sh_ff <= sh_in;
      rem_ff <= rem_in; tot_ff <= tot_in; q_ff <= q_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = st_ff;
   assign rsp_letter_code      = lc_ff;
   assign rsp_con_before_share = sh_ff[4*(FracBits+1)-1 -: FracBits+1];
   assign rsp_vow_before_share = sh_ff[3*(FracBits+1)-1 -: FracBits+1];
   assign rsp_con_after_share  = sh_ff[2*(FracBits+1)-1 -: FracBits+1];
   assign rsp_vow_after_share  = sh_ff[FracBits:0];
   assign rsp_con_before_count = cnt_ff[CW-1 -: CountBits];
   assign rsp_vow_before_count = cnt_ff[3*CountBits-1 -: CountBits];
   assign rsp_con_after_count  = cnt_ff[2*CountBits-1 -: CountBits];
   assign rsp_vow_after_count  = cnt_ff[CountBits-1:0];
endmodule

// ===== rtl/lch_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module lch_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== rtl/lch_checker.sv =====
// Port-level checker for the letter context histogram, bound to the top level.
module lch_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status
);
   import lch_pkg::*;

   // A new request is never taken while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response pending");
   // After a taken request, ready is low in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready held after transfer");
   // Status codes are only the defined ones.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL
                     || rsp_status == ST_BAD_IDX)) else $error("bad status");
   // A stalled response holds its status.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response changed");
endmodule

bind letter_context_histogram_unit lch_checker u_lch_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status));

// ===== tb/testbench.sv =====
// Self-checking testbench for the letter context histogram unit.
`timescale 1ns / 1ps

module testbench;
   import lch_pkg::*;

   // Payload of one request transfer.
   typedef struct packed {
      op_type          op;
      logic [20:0]     code_point;
      logic            is_vowel;
      logic            is_consonant;
      logic [5:0]      entry_index;
   } req_type;

   // Payload of one response transfer.
   typedef struct packed {
      logic [1:0]      status;
      logic [20:0]     letter_code;
      logic [16:0]     con_before_share;
      logic [16:0]     vow_before_share;
      logic [16:0]     con_after_share;
      logic [16:0]     vow_after_share;
      logic [31:0]     con_before_count;
      logic [31:0]     vow_before_count;
      logic [31:0]     con_after_count;
      logic [31:0]     vow_after_count;
   } rsp_type;

   // Keeps its own copy of the letter table and the neighbour counters, works out the
   // response to every accepted request and checks the responses in order.
   class histogram_scoreboard;
      logic [20:0] codes [64];
      logic [1:0]  classes [64];
      int          num_letters;
      logic [31:0] cb [64];
      logic [31:0] vb [64];
      logic [31:0] ca [64];
      logic [31:0] va [64];
      bit          last_seen;
      bit          last_tracked;
      int          last_entry;
      logic [1:0]  last_class;
      rsp_type     expected_responses [$];
      int          mismatches;

      function new();
         num_letters = 0;
         mismatches = 0;
         last_seen = 0;
         last_tracked = 0;
         last_entry = 0;
         last_class = 2'b00;
         for (int i = 0; i < 64; i++) begin
            codes[i] = '0;
            classes[i] = '0;
            cb[i] = '0;
            vb[i] = '0;
            ca[i] = '0;
            va[i] = '0;
         end
      endfunction

      function int lookup(logic [20:0] cp);
         for (int i = 0; i < num_letters; i++)
            if (codes[i] == cp)
               return i;
         return -1;
      endfunction

      function void bump(ref logic [31:0] c);
         if (c != 32'hFFFF_FFFF)
            c = c + 1;
      endfunction

      // Consonant share in Q1.16 and its vowel complement; both zero with no neighbours.
      function void shares(logic [31:0] con, logic [31:0] vow,
                           output logic [16:0] cs, output logic [16:0] vs);
         logic [63:0] total;
         logic [63:0] q;
         total = 64'(con) + 64'(vow);
         if (total == 0) begin
            cs = '0;
            vs = '0;
         end else begin
            q = (64'(con) << 16) / total;
            cs = q[16:0];
            vs = 17'(65536 - q);
         end
      endfunction

      function void note_request(req_type r);
         rsp_type    e;
         int         hit;
         logic [1:0] c;
         e = '0;
         e.status = ST_OK;
         case (r.op)
            OP_DEFINE: begin
               hit = lookup(r.code_point);
               if (hit >= 0) begin
                  classes[hit] |= {r.is_consonant, r.is_vowel};
               end else if (num_letters < 64) begin
                  codes[num_letters] = r.code_point;
                  classes[num_letters] = {r.is_consonant, r.is_vowel};
                  num_letters++;
               end else begin
                  e.status = ST_FULL;
               end
            end
            OP_CHAR: begin
               hit = lookup(r.code_point);
               c = (hit >= 0) ? classes[hit] : 2'b00;
               if (last_seen) begin
                  if (last_tracked) begin
                     if (c[1]) bump(ca[last_entry]);
                     if (c[0]) bump(va[last_entry]);
                  end
                  if (hit >= 0) begin
                     if (last_class[1]) bump(cb[hit]);
                     if (last_class[0]) bump(vb[hit]);
                  end
               end
               last_seen = 1;
               last_tracked = (hit >= 0);
               last_entry = (hit >= 0) ? hit : 0;
               last_class = c;
            end
            OP_EOL: begin
               last_seen = 0;
               last_tracked = 0;
               last_entry = 0;
               last_class = 2'b00;
            end
            default: begin
               if (int'(r.entry_index) >= num_letters) begin
                  e.status = ST_BAD_IDX;
               end else begin
                  e.letter_code = codes[r.entry_index];
                  shares(cb[r.entry_index], vb[r.entry_index],
                         e.con_before_share, e.vow_before_share);
                  shares(ca[r.entry_index], va[r.entry_index],
                         e.con_after_share, e.vow_after_share);
                  e.con_before_count = cb[r.entry_index];
                  e.vow_before_count = vb[r.entry_index];
                  e.con_after_count = ca[r.entry_index];
                  e.vow_after_count = va[r.entry_index];
               end
            end
         endcase
         expected_responses.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response with nothing outstanding: %p", got);
            return;
         end
         e = expected_responses.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response mismatch at %0t\n  expected %p\n  actual   %p",
                        $realtime, e, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lch_if #(.payload_type(req_type)) req_ch (clock);
   lch_if #(.payload_type(rsp_type)) rsp_ch (clock);

   histogram_scoreboard scoreboard;

   // Set by the sender to ask the response side for one long hold-off.
   bit hold_request;
   // While set, neither side idles.
   bit burst_mode;
   logic [20:0] known_codes [$];

   letter_context_histogram_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_ch.valid),
      .req_ready            (req_ch.ready),
      .req_op               (req_ch.payload.op),
      .req_code_point       (req_ch.payload.code_point),
      .req_is_vowel         (req_ch.payload.is_vowel),
      .req_is_consonant     (req_ch.payload.is_consonant),
      .req_entry_index      (req_ch.payload.entry_index),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_status           (rsp_ch.payload.status),
      .rsp_letter_code      (rsp_ch.payload.letter_code),
      .rsp_con_before_share (rsp_ch.payload.con_before_share),
      .rsp_vow_before_share (rsp_ch.payload.vow_before_share),
      .rsp_con_after_share  (rsp_ch.payload.con_after_share),
      .rsp_vow_after_share  (rsp_ch.payload.vow_after_share),
      .rsp_con_before_count (rsp_ch.payload.con_before_count),
      .rsp_vow_before_count (rsp_ch.payload.vow_before_count),
      .rsp_con_after_count  (rsp_ch.payload.con_after_count),
      .rsp_vow_after_count  (rsp_ch.payload.vow_after_count)
   );

   // The clock runs at 50 MHz.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length in cycles: mostly none or a few, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Both monitors sample at the rising edge, before any of this edge's updates land, so
   // they see exactly the values that the design saw when the transfer happened.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         scoreboard.note_request(req_ch.payload);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         scoreboard.check_response(rsp_ch.payload);
   end

   // Offers one request and returns once it has been transferred. The valid line is left
   // high, so back-to-back requests never lower and raise it within the same step.
   task automatic send_request(req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   task automatic send_op(op_type op, logic [20:0] cp, logic vow, logic con, logic [5:0] idx);
      req_type r;
      r.op = op;
      r.code_point = cp;
      r.is_vowel = vow;
      r.is_consonant = con;
      r.entry_index = idx;
      send_request(r);
   endtask

   // Text characters come mostly from letters already defined, so that the neighbour
   // counters actually move; the rest are arbitrary 21-bit values.
   function automatic logic [20:0] pick_char();
      if (known_codes.size() > 0 && $urandom_range(0, 99) < 80)
         return known_codes[$urandom_range(0, known_codes.size() - 1)];
      return 21'($urandom);
   endfunction

   // Response side: random stalls, plus one long hold-off on request from the sender.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (!burst_mode && $urandom_range(0, 99) < 30) begin
            rsp_ch.ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Hard limit on the length of the run.
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int pick;
      int waited;
      logic [20:0] cp;
      scoreboard = new();
      hold_request = 1'b0;
      burst_mode = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: each letter class, redefinition, extreme code points, untracked
      // characters, a define in the middle of a line, line ends and reads in and out of range.
      send_op(OP_DEFINE, 21'h61, 1'b1, 1'b0, '0);
      send_op(OP_DEFINE, 21'h62, 1'b0, 1'b1, '0);
      send_op(OP_DEFINE, 21'h79, 1'b1, 1'b1, '0);
      send_op(OP_DEFINE, 21'h0, 1'b0, 1'b0, '0);
      send_op(OP_DEFINE, 21'h1FFFFF, 1'b0, 1'b1, '0);
      send_op(OP_DEFINE, 21'h62, 1'b1, 1'b0, '0);
      send_op(OP_CHAR, 21'h62, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h61, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h79, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h1FFFFF, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h0, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h78, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h61, 1'b0, 1'b0, '0);
      send_op(OP_DEFINE, 21'h63, 1'b0, 1'b1, '0);
      send_op(OP_CHAR, 21'h63, 1'b0, 1'b0, '0);
      send_op(OP_EOL, 21'h0, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h61, 1'b0, 1'b0, '0);
      send_op(OP_CHAR, 21'h62, 1'b0, 1'b0, '0);
      for (int i = 0; i < 6; i++)
         send_op(OP_READ, 21'h0, 1'b0, 1'b0, 6'(i));
      send_op(OP_READ, 21'h1FFFFF, 1'b1, 1'b1, 6'h3F);
      known_codes = '{21'h61, 21'h62, 21'h79, 21'h0, 21'h1FFFFF, 21'h63};

      // Random part: mostly text over defined letters, with defines that gradually fill
      // the table and then run into it being full, line ends and reads of any index.
      for (int n = 0; n < 1730; n++) begin
         burst_mode = (n >= 400 && n < 550);
         if (n == 800)
            hold_request = 1'b1;
         if (n == 1200) begin
            req_ch.valid <= 1'b0;
            while (scoreboard.expected_responses.size() != 0)
               @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            if (known_codes.size() > 0 && $urandom_range(0, 2) == 0)
               cp = known_codes[$urandom_range(0, known_codes.size() - 1)];
            else
               cp = 21'($urandom);
            if (known_codes.size() < 64 && scoreboard.lookup(cp) < 0)
               known_codes.push_back(cp);
            send_op(OP_DEFINE, cp, 1'($urandom), 1'($urandom), 6'($urandom));
         end else if (pick < 70) begin
            send_op(OP_CHAR, pick_char(), 1'($urandom), 1'($urandom), 6'($urandom));
         end else if (pick < 78) begin
            send_op(OP_EOL, 21'($urandom), 1'($urandom), 1'($urandom), 6'($urandom));
         end else begin
            send_op(OP_READ, 21'($urandom), 1'($urandom), 1'($urandom), 6'($urandom));
         end
      end
      req_ch.valid <= 1'b0;

      // Drain the outstanding responses, then allow a little longer for stray ones.
      waited = 0;
      while (scoreboard.expected_responses.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.expected_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
